[sv/hav_pkg.sv]
package hav_pkg;

	// datapath widths
	localparam int ROT_W   = 32;  // rotation CORDIC x, y, z
	localparam int VEC_W   = 34;  // vectoring CORDIC x, y
	localparam int W_BITS  = 34;  // offset angle word fed to the phase divider
	localparam int DIV_BITS = 4;  // quotient bits per divider cell
	localparam int REM_W   = 10;  // divider remainder, span is at most 720
	localparam int SQ_STEPS = 31; // root bits of a 62-bit radicand
	localparam int SQ_REM_W = 34;
	localparam int DIST_W  = 26;

	localparam logic signed [ROT_W-1:0] GAIN_Q30 = 32'sd652032874;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] PI_Q29  = 31'd1686629713;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [15:0] RADIUS_RESET = 16'd6371;

	// arctangent of 2^-i in binary angle units, 2^32 per turn
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ROT_W-1:0] z;
		logic [1:0]              quad;
	} rot_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ROT_W-1:0] z;
	} vec_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_STEPS-1:0] root;
		logic [2*SQ_STEPS-1:0] op;
	} sqrt_t;

endpackage

[sv/hav_div_cell.sv]
module hav_div_cell
	import hav_pkg::*;
#(
	parameter int SPAN  = 720,
	parameter int NUM_W = 48
) (
	input  logic             clk,
	input  logic             en,
	input  logic [REM_W-1:0] rem_i,
	input  logic [NUM_W-1:0] num_i,
	input  logic [31:0]      quo_i,
	output logic [REM_W-1:0] rem_q,
	output logic [NUM_W-1:0] num_q,
	output logic [31:0]      quo_q
);

	localparam logic [REM_W:0] SPAN_V = (REM_W+1)'(SPAN);

	logic [REM_W-1:0] rem_c;
	logic [31:0]      quo_c;

	// long division, a few quotient bits from the top of the dividend
	always_comb begin
		logic [REM_W:0] r;
		rem_c = rem_i;
		quo_c = quo_i;
		for (int k = 0; k < DIV_BITS; k++) begin
			r = {rem_c, num_i[NUM_W-1-k]};
			if (r >= SPAN_V) begin
				r = r - SPAN_V;
				quo_c = {quo_c[30:0], 1'b1};
			end else begin
				quo_c = {quo_c[30:0], 1'b0};
			end
			rem_c = r[REM_W-1:0];
		end
	end

	// hand to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_c;
			num_q <= {num_i[NUM_W-1-DIV_BITS:0], {DIV_BITS{1'b0}}};
			quo_q <= quo_c;
		end
	end

endmodule

[sv/hav_rot_cell.sv]
module hav_rot_cell
	import hav_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic en,
	input  rot_t d_i,
	output rot_t d_q
);

	rot_t d_c;

	// rotate toward zero residual angle
	always_comb begin
		logic signed [ROT_W-1:0] sx, sy, at;
		sx = d_i.x >>> IDX;
		sy = d_i.y >>> IDX;
		at = signed'(ATAN_TAB[IDX]);
		d_c.quad = d_i.quad;
		if (!d_i.z[ROT_W-1]) begin
			d_c.x = d_i.x - sy;
			d_c.y = d_i.y + sx;
			d_c.z = d_i.z - at;
		end else begin
			d_c.x = d_i.x + sy;
			d_c.y = d_i.y - sx;
			d_c.z = d_i.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_c;
		end
	end

endmodule

[sv/hav_sqrt_cell.sv]
module hav_sqrt_cell
	import hav_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  sqrt_t d_i,
	output sqrt_t d_q
);

	sqrt_t d_c;

	// one root bit from the next bit pair of the radicand
	always_comb begin
		logic [SQ_REM_W-1:0] r2, trial;
		r2    = {d_i.rem[SQ_REM_W-3:0], d_i.op[2*SQ_STEPS-1 -: 2]};
		trial = {1'b0, d_i.root, 2'b01};
		d_c.op = {d_i.op[2*SQ_STEPS-3:0], 2'b00};
		if (r2 >= trial) begin
			d_c.rem  = r2 - trial;
			d_c.root = {d_i.root[SQ_STEPS-2:0], 1'b1};
		end else begin
			d_c.rem  = r2;
			d_c.root = {d_i.root[SQ_STEPS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_c;
		end
	end

endmodule

[sv/hav_vec_cell.sv]
module hav_vec_cell
	import hav_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic en,
	input  vec_t d_i,
	output vec_t d_q
);

	vec_t d_c;

	// rotate the vector onto the x axis, sum the angle
	always_comb begin
		logic signed [VEC_W-1:0] sx, sy;
		logic signed [ROT_W-1:0] at;
		sx = d_i.x >>> IDX;
		sy = d_i.y >>> IDX;
		at = signed'(ATAN_TAB[IDX]);
		if (!d_i.y[VEC_W-1]) begin
			d_c.x = d_i.x + sy;
			d_c.y = d_i.y - sx;
			d_c.z = d_i.z + at;
		end else begin
			d_c.x = d_i.x - sy;
			d_c.y = d_i.y + sx;
			d_c.z = d_i.z - at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_c;
		end
	end

endmodule

[sv/haversine_distance.sv]
// Great-circle distance between two points by the haversine formula. One point pair
// enters per clock and one distance leaves per clock; the pipeline is the chain of
// phase divider cells, the rotation and vectoring CORDIC cells and the two lanes of
// 31 square-root cells, with the product, clamp and scaling registers between them.
// A stalled output holds the whole chain.
// radius_km is written on the cfg channel and should only change while the block is
// empty; the distance comes in 1/2^DIST_FRAC_BITS km and saturates at 2^26 - 1.
module haversine_distance
	import hav_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 22,
	parameter int CORDIC_STAGES   = 24,
	parameter int DIST_FRAC_BITS  = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // lat_a[29:0], lon_a[60:30], lat_b[90:61], lon_b[121:91]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // distance[25:0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	localparam int G_SH   = 32 - ANGLE_FRAC_BITS;
	localparam int DSTG   = (W_BITS + G_SH + DIV_BITS - 1) / DIV_BITS;
	localparam int NDP    = DSTG * DIV_BITS;
	localparam longint M720 = longint'(720) << ANGLE_FRAC_BITS;
	localparam longint M360 = longint'(360) << ANGLE_FRAC_BITS;
	localparam longint OFF720 = ((longint'(1) << 31) + M720 - 1) / M720 * M720;
	localparam longint OFF360 = ((longint'(1) << 31) + M360 - 1) / M360 * M360;
	localparam int LAT    = 1 + DSTG + CORDIC_STAGES + 3 + SQ_STEPS + CORDIC_STAGES + 3;
	localparam int SH     = 30 - DIST_FRAC_BITS;
	localparam logic [48:0] HALF = 49'(1) << (29 - DIST_FRAC_BITS);

	logic adv;
	logic [LAT-1:0] vld_q;
	logic [15:0] radius_q;

	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = vld_q[LAT-1];

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	// advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// offset angles to nonnegative words: latitude and longitude differences and both latitudes
	logic signed [W_BITS-1:0] lat_a_x, lat_b_x, lon_a_x, lon_b_x;
	logic [W_BITS-1:0] w_s1 [4];

	assign lat_a_x = W_BITS'(signed'(s_tdata[29:0]));
	assign lon_a_x = W_BITS'(signed'(s_tdata[60:30]));
	assign lat_b_x = W_BITS'(signed'(s_tdata[90:61]));
	assign lon_b_x = W_BITS'(signed'(s_tdata[121:91]));

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1[0] <= W_BITS'(lat_b_x - lat_a_x + W_BITS'(OFF720));
			w_s1[1] <= W_BITS'(lon_b_x - lon_a_x + W_BITS'(OFF720));
			w_s1[2] <= W_BITS'(lat_a_x + W_BITS'(OFF360));
			w_s1[3] <= W_BITS'(lat_b_x + W_BITS'(OFF360));
		end
	end

	// phase dividers, then rotation CORDIC, one lane per angle
	logic [REM_W-1:0] drem [4][DSTG+1];
	logic [NDP-1:0]   dnum [4][DSTG+1];
	logic [31:0]      dquo [4][DSTG+1];
	rot_t             rt   [4][CORDIC_STAGES+1];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		localparam int SPAN = (l < 2) ? 720 : 360;
		assign drem[l][0] = '0;
		assign dquo[l][0] = '0;
		assign dnum[l][0] = NDP'({w_s1[l], {G_SH{1'b0}}});
		for (genvar k = 0; k < DSTG; k++) begin : g_div
			hav_div_cell #(.SPAN(SPAN), .NUM_W(NDP)) u_div (
				.clk   (clk),
				.en    (adv),
				.rem_i (drem[l][k]),
				.num_i (dnum[l][k]),
				.quo_i (dquo[l][k]),
				.rem_q (drem[l][k+1]),
				.num_q (dnum[l][k+1]),
				.quo_q (dquo[l][k+1])
			);
		end
		assign rt[l][0].x    = GAIN_Q30;
		assign rt[l][0].y    = '0;
		assign rt[l][0].z    = signed'({2'b00, dquo[l][DSTG][29:0]});
		assign rt[l][0].quad = dquo[l][DSTG][31:30];
		for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
			hav_rot_cell #(.IDX(k)) u_rot (
				.clk (clk),
				.en  (adv),
				.d_i (rt[l][k]),
				.d_q (rt[l][k+1])
			);
		end
	end

	// fold the quadrant back into sine and cosine
	logic signed [ROT_W-1:0] sn [4];
	logic signed [ROT_W-1:0] cs [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			unique case (rt[l][CORDIC_STAGES].quad)
				2'd0: begin
					cs[l] = rt[l][CORDIC_STAGES].x;
					sn[l] = rt[l][CORDIC_STAGES].y;
				end
				2'd1: begin
					cs[l] = -rt[l][CORDIC_STAGES].y;
					sn[l] = rt[l][CORDIC_STAGES].x;
				end
				2'd2: begin
					cs[l] = -rt[l][CORDIC_STAGES].x;
					sn[l] = -rt[l][CORDIC_STAGES].y;
				end
				default: begin
					cs[l] = rt[l][CORDIC_STAGES].y;
					sn[l] = -rt[l][CORDIC_STAGES].x;
				end
			endcase
		end
	end

	// sine squares, cosine product and its product with the longitude sine square
	logic signed [63:0] p_lat, p_lon, p_cc, p_m2;
	logic signed [ROT_W-1:0] slat2_s1, slon2_s1, cc_s1, slat2_s2;
	logic signed [63:0] p_s2;
	logic [30:0] a_s3;

	assign p_lat = sn[0] * sn[0];
	assign p_lon = sn[1] * sn[1];
	assign p_cc  = cs[2] * cs[3];
	assign p_m2  = cc_s1 * slon2_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			slat2_s1 <= p_lat[61:30];
			slon2_s1 <= p_lon[61:30];
			cc_s1    <= p_cc[61:30];
			slat2_s2 <= slat2_s1;
			p_s2     <= p_m2;
		end
	end

	// sum and clamp a to the unit interval
	logic signed [ROT_W:0] a_sum;
	assign a_sum = (ROT_W+1)'(slat2_s2) + (ROT_W+1)'(signed'(p_s2[61:30]));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (a_sum[ROT_W]) begin
				a_s3 <= '0;
			end else if (a_sum > signed'({2'b00, ONE_Q30})) begin
				a_s3 <= ONE_Q30;
			end else begin
				a_s3 <= a_sum[30:0];
			end
		end
	end

	// square roots of a and 1 - a
	sqrt_t sq [2][SQ_STEPS+1];
	logic [30:0] b_c;

	assign b_c = ONE_Q30 - a_s3;
	assign sq[0][0] = '{rem: '0, root: '0, op: {1'b0, a_s3, 30'd0}};
	assign sq[1][0] = '{rem: '0, root: '0, op: {1'b0, b_c, 30'd0}};

	for (genvar l = 0; l < 2; l++) begin : g_sq
		for (genvar k = 0; k < SQ_STEPS; k++) begin : g_cell
			hav_sqrt_cell u_sq (
				.clk (clk),
				.en  (adv),
				.d_i (sq[l][k]),
				.d_q (sq[l][k+1])
			);
		end
	end

	// vectoring CORDIC for the central half angle
	vec_t vc [CORDIC_STAGES+1];

	assign vc[0].x = signed'(VEC_W'(sq[1][SQ_STEPS].root));
	assign vc[0].y = signed'(VEC_W'(sq[0][SQ_STEPS].root));
	assign vc[0].z = '0;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
		hav_vec_cell #(.IDX(k)) u_vec (
			.clk (clk),
			.en  (adv),
			.d_i (vc[k]),
			.d_q (vc[k+1])
		);
	end

	// clamp the angle, scale to radians, then by radius, round and saturate
	logic signed [ROT_W-1:0] z_f;
	logic [30:0] z_c;
	logic [61:0] t_c;
	logic [31:0] t_s1;
	logic [47:0] d_s2;
	logic [48:0] d_sum;
	logic [48:0] d_sh;
	logic [DIST_W-1:0] dist_q;

	assign z_f = vc[CORDIC_STAGES].z;

	always_comb begin
		if (z_f[ROT_W-1]) begin
			z_c = '0;
		end else if (z_f > signed'({1'b0, ONE_Q30})) begin
			z_c = ONE_Q30;
		end else begin
			z_c = z_f[30:0];
		end
	end

	assign t_c   = z_c * PI_Q29;
	assign d_sum = 49'(d_s2) + HALF;
	assign d_sh  = d_sum >> SH;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= t_c[60:29];
			d_s2 <= radius_q * t_s1;
			if (d_sh > 49'(DIST_MAX)) begin
				dist_q <= DIST_MAX;
			end else begin
				dist_q <= d_sh[DIST_W-1:0];
			end
		end
	end

	assign m_tdata = {{(32-DIST_W){1'b0}}, dist_q};

endmodule
